// ----- hw/rtl/ssl_pkg.sv -----
// ----------------------------------------------------------------------------
// Step sequencer package
// Shared constants, codes, record types and the filter cutoff table.
// ----------------------------------------------------------------------------
package ssl_pkg;

  localparam int NUM_STEPS = 32;
  localparam int NUM_SLOTS = 6;
  localparam int IDX_W     = $clog2(NUM_STEPS);
  localparam int SLOT_W    = $clog2(NUM_SLOTS);
  localparam int MAX_ITER  = 9;
  localparam int ITER_W    = $clog2(MAX_ITER + 1);

  localparam int TIME_W       = 20;
  localparam int SUM_W        = TIME_W + 1;
  localparam int STEP_US_W    = 18;
  localparam int LOOKAHEAD_US = 34000;
  localparam int TIME_MIN     = -(2 ** (TIME_W - 1));
  localparam int US_PER_MS    = 1000;

  // floor(t / 1000) == (t * DIV_MUL) >> DIV_SHIFT for every t below 2^16.
  localparam int DIV_MUL   = 67109;
  localparam int DIV_SHIFT = 26;
  localparam int PROD_W    = 33;

  localparam logic [1:0] REQ_WRITE  = 2'd0;
  localparam logic [1:0] REQ_TOGGLE = 2'd1;
  localparam logic [1:0] REQ_TICK   = 2'd2;

  localparam logic [1:0] CFG_STEP_MS     = 2'd0;
  localparam logic [1:0] CFG_RESONANCE   = 2'd1;
  localparam logic [1:0] CFG_LOOP_ENABLE = 2'd2;

  localparam logic [7:0]  STEP_MS_RESET   = 8'd80;
  localparam logic [3:0]  RESONANCE_RESET = 4'd6;
  localparam logic [7:0]  DUR_PAD         = 8'd5;
  localparam logic [3:0]  SLOT_BASE       = 4'd10;
  localparam logic [3:0]  CUT_OFF         = 4'd15;
  localparam logic [11:0] OFF_HZ          = 12'd1000;
  localparam logic [6:0]  RESET_PITCH     = 7'd36;

  typedef struct packed {
    logic [6:0] pitch;
    logic [2:0] wave;
    logic [2:0] vol;
    logic [3:0] cut;
  } step_t;

  localparam int STEP_W = $bits(step_t);

  localparam step_t RESET_STEP = '{pitch: RESET_PITCH, wave: 3'd0, vol: 3'd0, cut: CUT_OFF};

  typedef struct packed {
    logic [5:0]  delay_ms;
    logic [6:0]  pitch;
    logic [3:0]  slot;
    logic [2:0]  wave;
    logic [2:0]  vol;
    logic [7:0]  dur;
    logic        filter_on;
    logic [11:0] cutoff;
    logic [3:0]  res;
  } hit_t;

  // floor(150 * 2^(c/3)) Hz for cut levels 0 to 14.
  function automatic logic [11:0] cut_hz(input logic [3:0] c);
    logic [11:0] hz;
    case (c)
      4'd0:    hz = 12'd150;
      4'd1:    hz = 12'd188;
      4'd2:    hz = 12'd238;
      4'd3:    hz = 12'd300;
      4'd4:    hz = 12'd377;
      4'd5:    hz = 12'd476;
      4'd6:    hz = 12'd600;
      4'd7:    hz = 12'd755;
      4'd8:    hz = 12'd952;
      4'd9:    hz = 12'd1200;
      4'd10:   hz = 12'd1511;
      4'd11:   hz = 12'd1904;
      4'd12:   hz = 12'd2400;
      4'd13:   hz = 12'd3023;
      4'd14:   hz = 12'd3809;
      default: hz = OFF_HZ;
    endcase
    return hz;
  endfunction

endpackage

// ----- hw/rtl/ssl_req_if.sv -----
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying write, toggle and tick words.
// ----------------------------------------------------------------------------
interface ssl_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [4:0]  step_index;
  logic [6:0]  note_pitch;
  logic [2:0]  wave_kind;
  logic [2:0]  step_volume;
  logic [3:0]  cut_level;
  logic [15:0] elapsed_us;

  modport source (
    output valid, req_type, step_index, note_pitch, wave_kind, step_volume,
           cut_level, elapsed_us,
    input  ready
  );
  modport sink (
    input  valid, req_type, step_index, note_pitch, wave_kind, step_volume,
           cut_level, elapsed_us,
    output ready
  );
endinterface

// ----- hw/rtl/ssl_hit_if.sv -----
// ----------------------------------------------------------------------------
// Hit channel
// Valid/ready channel carrying one scheduled hit per word.
// ----------------------------------------------------------------------------
interface ssl_hit_if;
  logic        valid;
  logic        ready;
  logic [5:0]  delay_ms;
  logic [6:0]  hit_pitch;
  logic [3:0]  voice_slot;
  logic [2:0]  hit_wave;
  logic [2:0]  hit_volume;
  logic [7:0]  duration_ms;
  logic        filter_on;
  logic [11:0] cutoff_hz;
  logic [3:0]  hit_resonance;
  logic        last;

  modport source (
    output valid, delay_ms, hit_pitch, voice_slot, hit_wave, hit_volume,
           duration_ms, filter_on, cutoff_hz, hit_resonance, last,
    input  ready
  );
  modport sink (
    input  valid, delay_ms, hit_pitch, voice_slot, hit_wave, hit_volume,
           duration_ms, filter_on, cutoff_hz, hit_resonance, last,
    output ready
  );
endinterface

// ----- hw/rtl/ssl_cfg_if.sv -----
// ----------------------------------------------------------------------------
// Configuration channel
// Valid/ready register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface ssl_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/ssl_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ssl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/step_sequencer_lookahead.sv -----
// ----------------------------------------------------------------------------
// Step sequencer with lookahead scheduling
// Stores steps, runs a signed microsecond timer and emits hits ahead of time.
// ----------------------------------------------------------------------------
// Write and toggle words are taken in the idle state. A tick goes through accept, subtract and check,
// then a step and a check per step handled (at most 9), then a flush for the final hit,
// and waits while the hit channel stalls. One timer adder is shared by the tick subtract and
// every step advance, and the step store is read through one registered port.
// After reset the block is stopped, every step reads silent (pitch 36, cut 15) through
// per-entry valid bits, and step_ms, resonance and loop_enable are 80, 6 and 0.
module step_sequencer_lookahead import ssl_pkg::*; (
  input logic      clk,
  input logic      rst,
  ssl_req_if.sink  req,
  ssl_hit_if.source hit,
  ssl_cfg_if.sink  cfg
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SUB   = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_STEP  = 3'd3;
  localparam logic [2:0] S_FLUSH = 3'd4;

  logic [2:0]                state;
  logic [7:0]                step_ms;
  logic [STEP_US_W-1:0]      step_us;
  logic [3:0]                resonance;
  logic                      loop_enable;
  logic                      playing;
  logic [IDX_W-1:0]          play_index;
  logic signed [TIME_W-1:0]  time_us;
  logic [SLOT_W-1:0]         slot_cnt;
  logic [ITER_W-1:0]         iter;
  logic [NUM_STEPS-1:0]      valid_bits;
  logic                      rd_valid;
  logic                      pend_valid;
  logic                      out_valid;
  logic [15:0]               elapsed;
  hit_t                      pend;
  hit_t                      out_q;
  logic                      out_last;

  logic                      in_fire;
  logic                      write_ok;
  logic [IDX_W-1:0]          waddr;
  step_t                     wstep;
  logic [STEP_W-1:0]         rd_data;
  step_t                     st;
  logic signed [SUM_W-1:0]   add_b;
  logic signed [SUM_W-1:0]   add_sum;
  logic signed [TIME_W-1:0]  time_next;
  logic [PROD_W-1:0]         prod;
  logic [8:0]                dur_sum;
  hit_t                      hit_new;
  logic                      emit;
  logic                      out_free;
  logic                      stall;
  logic                      more;

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign in_fire   = req.valid && req.ready;

  // Step store
  assign write_ok = in_fire && (req.req_type == REQ_WRITE) && (int'(req.step_index) < NUM_STEPS);
  assign waddr    = IDX_W'(req.step_index);
  assign wstep    = '{pitch: req.note_pitch, wave: req.wave_kind,
                      vol: req.step_volume, cut: req.cut_level};

  ssl_ram #(.WIDTH(STEP_W), .DEPTH(NUM_STEPS)) u_store (
    .clk   (clk),
    .we    (write_ok),
    .waddr (waddr),
    .wdata (wstep),
    .raddr (play_index),
    .rdata (rd_data)
  );

  assign st = rd_valid ? step_t'(rd_data) : RESET_STEP;

  // Shared timer adder: subtracts the elapsed time on a tick, adds one step otherwise.
  always_comb begin
    if (state == S_SUB) begin
      add_b = SUM_W'(0) - $signed(SUM_W'(elapsed));
    end else begin
      add_b = $signed(SUM_W'(step_us));
    end
    add_sum = SUM_W'(time_us) + add_b;
    if (add_sum < SUM_W'(TIME_MIN)) begin
      time_next = TIME_W'(TIME_MIN);
    end else begin
      time_next = add_sum[TIME_W-1:0];
    end
  end

  assign more = playing && (time_us < TIME_W'(LOOKAHEAD_US)) && (iter < ITER_W'(MAX_ITER));

  // Hit formation. The timer is below the lookahead here, so its low 16 bits suffice.
  assign prod    = PROD_W'(time_us[15:0]) * PROD_W'(DIV_MUL);
  assign dur_sum = {1'b0, step_ms} + {1'b0, DUR_PAD};

  always_comb begin
    hit_new.delay_ms  = (time_us > 0) ? prod[DIV_SHIFT +: 6] : 6'd0;
    hit_new.pitch     = st.pitch;
    hit_new.slot      = SLOT_BASE + 4'(slot_cnt);
    hit_new.wave      = st.wave;
    hit_new.vol       = st.vol;
    hit_new.dur       = dur_sum[8] ? 8'hFF : dur_sum[7:0];
    hit_new.filter_on = (st.cut != CUT_OFF);
    hit_new.cutoff    = (st.cut != CUT_OFF) ? cut_hz(st.cut) : OFF_HZ;
    hit_new.res       = (st.cut != CUT_OFF) ? resonance : 4'd0;
  end

  // A hit waits in pend until the next hit or the end of the tick tells whether it is last.
  assign emit     = (st.vol != 3'd0);
  assign out_free = !out_valid || hit.ready;
  assign stall    = emit && pend_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      step_ms     <= STEP_MS_RESET;
      step_us     <= STEP_US_W'(int'(STEP_MS_RESET) * US_PER_MS);
      resonance   <= RESONANCE_RESET;
      loop_enable <= 1'b0;
      playing     <= 1'b0;
      play_index  <= '0;
      time_us     <= '0;
      slot_cnt    <= '0;
      iter        <= '0;
      valid_bits  <= '0;
      rd_valid    <= 1'b0;
      pend_valid  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      rd_valid <= valid_bits[play_index];
      if (out_valid && hit.ready) begin
        out_valid <= 1'b0;
      end
      if (write_ok) begin
        valid_bits[waddr] <= 1'b1;
      end

      if (cfg.valid) begin
        case (cfg.index)
          CFG_STEP_MS: begin
            step_ms <= cfg.data;
            step_us <= STEP_US_W'(STEP_US_W'(cfg.data) * STEP_US_W'(US_PER_MS));
          end
          CFG_RESONANCE:   resonance   <= cfg.data[3:0];
          CFG_LOOP_ENABLE: loop_enable <= cfg.data[0];
          default: ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (in_fire) begin
            case (req.req_type)
              REQ_TOGGLE: begin
                if (!playing) begin
                  playing <= 1'b1;
                  time_us <= '0;
                end else begin
                  playing <= 1'b0;
                end
                play_index <= '0;
              end
              REQ_TICK: begin
                iter  <= '0;
                state <= S_SUB;
              end
              default: ;
            endcase
          end
        end
        S_SUB: begin
          if (playing) begin
            time_us <= time_next;
          end
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (more) begin
            state <= S_STEP;
          end else if (pend_valid) begin
            state <= S_FLUSH;
          end else begin
            state <= S_IDLE;
          end
        end
        S_STEP: begin
          if (!stall) begin
            if (emit) begin
              if (pend_valid) begin
                out_valid <= 1'b1;
              end
              pend_valid <= 1'b1;
              slot_cnt   <= (slot_cnt == SLOT_W'(NUM_SLOTS - 1)) ? '0 :
                            SLOT_W'(slot_cnt + 1'b1);
            end
            time_us <= time_next;
            iter    <= ITER_W'(iter + 1'b1);
            if (play_index == IDX_W'(NUM_STEPS - 1)) begin
              play_index <= '0;
              if (!loop_enable) begin
                playing <= 1'b0;
              end
            end else begin
              play_index <= IDX_W'(play_index + 1'b1);
            end
            state <= S_CHECK;
          end
        end
        S_FLUSH: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      elapsed <= req.elapsed_us;
    end
    if (state == S_STEP && emit && !stall) begin
      pend <= hit_new;
      if (pend_valid) begin
        out_q    <= pend;
        out_last <= 1'b0;
      end
    end
    if (state == S_FLUSH && out_free) begin
      out_q    <= pend;
      out_last <= 1'b1;
    end
  end

  assign hit.valid         = out_valid;
  assign hit.delay_ms      = out_q.delay_ms;
  assign hit.hit_pitch     = out_q.pitch;
  assign hit.voice_slot    = out_q.slot;
  assign hit.hit_wave      = out_q.wave;
  assign hit.hit_volume    = out_q.vol;
  assign hit.duration_ms   = out_q.dur;
  assign hit.filter_on     = out_q.filter_on;
  assign hit.cutoff_hz     = out_q.cutoff;
  assign hit.hit_resonance = out_q.res;
  assign hit.last          = out_last;

endmodule

// ----- hw/rtl/ssl_checker.sv -----
// ----------------------------------------------------------------------------
// Step sequencer port checker
// Checks tick handling and hit words as seen on the top-level ports.
// ----------------------------------------------------------------------------
module ssl_checker import ssl_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic [1:0]  req_type,
  input logic        hit_valid,
  input logic        hit_ready,
  input logic [3:0]  voice_slot,
  input logic        filter_on,
  input logic [11:0] cutoff_hz,
  input logic [3:0]  hit_resonance,
  input logic [48:0] hit_word
);

  localparam logic [3:0] SLOT_TOP = 4'(int'(SLOT_BASE) + NUM_SLOTS - 1);

  // In the cycle after a tick is taken the block is not ready for a new request.
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (req_type == REQ_TICK) |=> !req_ready)
    else $error("request ready right after a tick was taken");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    hit_valid |-> (voice_slot >= SLOT_BASE) && (voice_slot <= SLOT_TOP))
    else $error("voice slot out of range");

  // With the filter off the hit carries the neutral cutoff and no resonance.
  a_filter_off: assert property (@(posedge clk) disable iff (rst)
    hit_valid && !filter_on |-> (cutoff_hz == OFF_HZ) && (hit_resonance == 4'd0))
    else $error("filter off but cutoff or resonance set");

  a_hit_hold: assert property (@(posedge clk) disable iff (rst)
    hit_valid && !hit_ready |=> hit_valid && $stable(hit_word))
    else $error("stalled hit word changed or dropped");

endmodule

bind step_sequencer_lookahead ssl_checker u_ssl_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .req_type      (req.req_type),
  .hit_valid     (hit.valid),
  .hit_ready     (hit.ready),
  .voice_slot    (hit.voice_slot),
  .filter_on     (hit.filter_on),
  .cutoff_hz     (hit.cutoff_hz),
  .hit_resonance (hit.hit_resonance),
  .hit_word      ({hit.delay_ms, hit.hit_pitch, hit.voice_slot, hit.hit_wave,
                   hit.hit_volume, hit.duration_ms, hit.filter_on, hit.cutoff_hz,
                   hit.hit_resonance, hit.last})
);
